// ----- rtl/dct_pkg.sv -----
`timescale 1ns / 1ps

package dct_pkg;

    localparam int POSITION_BITS = 16;
    localparam int BYTE_BITS     = 8;
    localparam int CLASS_WORD_BITS = 64;
    localparam int CLASS_WORDS   = 4;
    localparam int CFG_IDX_BITS  = 4;

    localparam logic [CFG_IDX_BITS-1:0] CFG_DROP_BASE = 4'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_STOP_BASE = 4'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_REG_COUNT = 4'd8;

    localparam int FIFO_DEPTH    = 8;
    localparam int FIFO_PTR_BITS = 3;
    localparam int FIFO_CNT_BITS = 4;

    localparam logic [POSITION_BITS-1:0] COUNT_MAX = {POSITION_BITS{1'b1}};

    typedef enum logic [1:0] {
        KIND_CONTENT = 2'd0,
        KIND_DELIM   = 2'd1,
        KIND_END     = 2'd2
    } t_kind;

    typedef struct packed {
        t_kind                    kind;
        logic [POSITION_BITS-1:0] start;
        logic [POSITION_BITS-1:0] length;
        logic [BYTE_BITS-1:0]     delim;
        logic                     last;
    } t_result;

    typedef struct packed {
        logic drop;
        logic stop;
    } t_class_flags;

    typedef struct packed {
        logic [1:0] count;
        t_result    res0;
        t_result    res1;
    } t_push;

    function automatic logic [POSITION_BITS-1:0] sat_inc(input logic [POSITION_BITS-1:0] v);
        sat_inc = (v == COUNT_MAX) ? COUNT_MAX : v + 1'b1;
    endfunction

endpackage

// ----- rtl/delimiter_class_tokenizer.sv -----
`timescale 1ns / 1ps

// Byte-stream tokenizer with programmable drop and stop character classes.
// Input channel: i_in_valid / o_in_stall carry one text byte per request on
// i_text_byte; byte 0 terminates the current text.
// Output channel: o_out_valid / i_out_stall carry one token result per
// request: kind, start offset, length, delimiter byte and a flag marking the
// last result caused by an input byte. One byte yields zero, one or two
// results.
// Class registers are written through i_cfg_we / i_cfg_index / i_cfg_data;
// the user must write them only while the block is idle, which the block does
// not enforce; indexes past the last register are ignored. An accepted byte is
// registered, classified from that register, and its results are queued.
// Throughput: one byte per cycle while o_in_stall is low. The output moves one
// result per cycle while i_out_stall is low, so two-result bytes pile up; the
// eight-entry result queue absorbs that, and o_in_stall rises when the queue
// could not take two more results after those of the byte in flight. When the
// receiver stalls, the head result holds and the queue fills until the input
// is stalled. Reset clears the class registers, the token state and the
// queue.
module delimiter_class_tokenizer (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_in_valid,
    output logic                                 o_in_stall,
    input  logic [dct_pkg::BYTE_BITS-1:0]        i_text_byte,
    input  logic                                 i_cfg_we,
    input  logic [dct_pkg::CFG_IDX_BITS-1:0]     i_cfg_index,
    input  logic [dct_pkg::CLASS_WORD_BITS-1:0]  i_cfg_data,
    output logic                                 o_out_valid,
    input  logic                                 i_out_stall,
    output logic [1:0]                           o_token_kind,
    output logic [dct_pkg::POSITION_BITS-1:0]    o_token_start,
    output logic [dct_pkg::POSITION_BITS-1:0]    o_token_length,
    output logic [dct_pkg::BYTE_BITS-1:0]        o_delim_byte,
    output logic                                 o_last_result
);
    import dct_pkg::*;

    logic [BYTE_BITS-1:0]     lookup_byte;
    t_class_flags             flags;
    t_push                    push;
    t_result                  head;
    logic [FIFO_CNT_BITS-1:0] fifo_count;
    logic                     in_accept;
    logic                     out_pop;
    logic [FIFO_CNT_BITS:0]   fill_worst;

    dct_class_regs u_class (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_byte      (lookup_byte),
        .o_flags     (flags)
    );

    dct_token_unit u_token (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (in_accept),
        .i_byte   (i_text_byte),
        .o_byte   (lookup_byte),
        .i_flags  (flags),
        .o_push   (push)
    );

    dct_result_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (out_pop),
        .o_count (fifo_count),
        .o_head  (head)
    );

    // Room is reserved for the byte in flight plus two results of a new one.
    assign fill_worst = {1'b0, fifo_count} + (FIFO_CNT_BITS + 1)'(push.count)
                        + (FIFO_CNT_BITS + 1)'(2);
    assign o_in_stall = (fill_worst > (FIFO_CNT_BITS + 1)'(FIFO_DEPTH));
    assign in_accept  = i_in_valid && !o_in_stall;

    assign o_out_valid = (fifo_count != '0);
    assign out_pop     = o_out_valid && !i_out_stall;

    assign o_token_kind   = head.kind;
    assign o_token_start  = head.start;
    assign o_token_length = head.length;
    assign o_delim_byte   = head.delim;
    assign o_last_result  = head.last;

endmodule

// ----- rtl/dct_class_regs.sv -----
`timescale 1ns / 1ps

module dct_class_regs (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_cfg_we,
    input  logic [dct_pkg::CFG_IDX_BITS-1:0]       i_cfg_index,
    input  logic [dct_pkg::CLASS_WORD_BITS-1:0]    i_cfg_data,
    input  logic [dct_pkg::BYTE_BITS-1:0]          i_byte,
    output dct_pkg::t_class_flags                  o_flags
);
    import dct_pkg::*;

    logic [CLASS_WORD_BITS-1:0] r_drop [CLASS_WORDS];
    logic [CLASS_WORD_BITS-1:0] r_stop [CLASS_WORDS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < CLASS_WORDS; i++) begin
                r_drop[i] <= '0;
                r_stop[i] <= '0;
            end
        end else if (i_cfg_we) begin
            if (i_cfg_index < CFG_STOP_BASE) begin
                r_drop[i_cfg_index[1:0]] <= i_cfg_data;
            end else if (i_cfg_index < CFG_REG_COUNT) begin
                r_stop[i_cfg_index[1:0]] <= i_cfg_data;
            end
        end
    end

    // Upper two bits of the byte pick the word, the lower six the flag.
    assign o_flags.drop = r_drop[i_byte[7:6]][i_byte[5:0]];
    assign o_flags.stop = r_stop[i_byte[7:6]][i_byte[5:0]];

endmodule

// ----- rtl/dct_token_unit.sv -----
`timescale 1ns / 1ps

module dct_token_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_accept,
    input  logic [dct_pkg::BYTE_BITS-1:0] i_byte,
    output logic [dct_pkg::BYTE_BITS-1:0] o_byte,
    input  dct_pkg::t_class_flags         i_flags,
    output dct_pkg::t_push                o_push
);
    import dct_pkg::*;

    logic                     r_in_valid;
    logic [BYTE_BITS-1:0]     r_byte;
    logic                     r_inside;
    logic [POSITION_BITS-1:0] r_pos;
    logic [POSITION_BITS-1:0] r_tok_start;
    logic [POSITION_BITS-1:0] r_tok_len;

    logic                     n_inside;
    logic [POSITION_BITS-1:0] n_pos;
    logic [POSITION_BITS-1:0] n_tok_start;
    logic [POSITION_BITS-1:0] n_tok_len;

    logic    is_end;
    logic    is_delim;
    logic    is_stop;
    logic    close_tok;
    logic    emit_b;
    t_result res_a;
    t_result res_b;

    always_comb begin
        is_end    = (r_byte == '0);
        is_delim  = !is_end && (i_flags.drop || i_flags.stop);
        // A byte in both classes counts as a drop byte.
        is_stop   = is_delim && !i_flags.drop;
        close_tok = r_inside && (is_end || is_delim);
        emit_b    = is_end || is_stop;

        res_a.kind   = KIND_CONTENT;
        res_a.start  = r_tok_start;
        res_a.length = r_tok_len;
        res_a.delim  = '0;
        res_a.last   = !emit_b;

        res_b.kind   = is_end ? KIND_END : KIND_DELIM;
        res_b.start  = r_pos;
        res_b.length = is_end ? '0 : POSITION_BITS'(1);
        res_b.delim  = is_end ? '0 : r_byte;
        res_b.last   = 1'b1;

        o_push.count = 2'd0;
        o_push.res0  = res_a;
        o_push.res1  = res_b;
        if (r_in_valid) begin
            if (close_tok && emit_b) begin
                o_push.count = 2'd2;
            end else if (close_tok) begin
                o_push.count = 2'd1;
            end else if (emit_b) begin
                o_push.count = 2'd1;
                o_push.res0  = res_b;
            end
        end

        n_inside    = r_inside;
        n_pos       = r_pos;
        n_tok_start = r_tok_start;
        n_tok_len   = r_tok_len;
        if (r_in_valid) begin
            if (is_end) begin
                n_inside    = 1'b0;
                n_pos       = '0;
                n_tok_start = '0;
                n_tok_len   = '0;
            end else if (is_delim) begin
                n_inside = 1'b0;
                n_pos    = sat_inc(r_pos);
            end else begin
                n_inside = 1'b1;
                n_pos    = sat_inc(r_pos);
                if (r_inside) begin
                    n_tok_len = sat_inc(r_tok_len);
                end else begin
                    n_tok_start = r_pos;
                    n_tok_len   = POSITION_BITS'(1);
                end
            end
        end
    end

    assign o_byte = r_byte;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_inside    <= 1'b0;
            r_pos       <= '0;
            r_tok_start <= '0;
            r_tok_len   <= '0;
        end else begin
            r_in_valid  <= i_accept;
            r_inside    <= n_inside;
            r_pos       <= n_pos;
            r_tok_start <= n_tok_start;
            r_tok_len   <= n_tok_len;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_byte <= i_byte;
        end
    end

endmodule

// ----- rtl/dct_result_fifo.sv -----
`timescale 1ns / 1ps

module dct_result_fifo (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  dct_pkg::t_push                     i_push,
    input  logic                               i_pop,
    output logic [dct_pkg::FIFO_CNT_BITS-1:0]  o_count,
    output dct_pkg::t_result                   o_head
);
    import dct_pkg::*;

    t_result                  r_mem [FIFO_DEPTH];
    logic [FIFO_PTR_BITS-1:0] r_wr_ptr;
    logic [FIFO_PTR_BITS-1:0] r_rd_ptr;
    logic [FIFO_CNT_BITS-1:0] r_count;

    logic [FIFO_PTR_BITS-1:0] wr_next;

    assign wr_next = r_wr_ptr + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= r_wr_ptr + FIFO_PTR_BITS'(i_push.count);
            r_rd_ptr <= r_rd_ptr + FIFO_PTR_BITS'(i_pop);
            r_count  <= r_count + FIFO_CNT_BITS'(i_push.count) - FIFO_CNT_BITS'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.count != 2'd0) begin
            r_mem[r_wr_ptr] <= i_push.res0;
        end
        if (i_push.count == 2'd2) begin
            r_mem[wr_next] <= i_push.res1;
        end
    end

    assign o_count = r_count;
    assign o_head  = r_mem[r_rd_ptr];

endmodule

// ----- verif/tb_delimiter_class_tokenizer.sv -----
`timescale 1ns / 1ps

module tb_delimiter_class_tokenizer;
    import dct_pkg::*;

    localparam int QUIET_LIMIT    = 3000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 20;
    localparam int HOLDOFF_CYCLES = 300;

    localparam logic [7:0] PLAIN_TEXT [6] = '{8'h61, 8'h62, 8'h00, 8'h00, 8'hFF, 8'h00};
    localparam logic [7:0] CLASS_TEXT [17] = '{
        8'h20, 8'h61, 8'h62, 8'h2C, 8'h2C, 8'h63, 8'h20, 8'h64, 8'h3B,
        8'h80, 8'h01, 8'hFF, 8'h65, 8'hFF, 8'h7F, 8'h00, 8'h00
    };

    class token_scoreboard;
        logic [CLASS_WORD_BITS-1:0] drop_words [CLASS_WORDS];
        logic [CLASS_WORD_BITS-1:0] stop_words [CLASS_WORDS];
        logic                       in_token;
        logic [POSITION_BITS-1:0]   position;
        logic [POSITION_BITS-1:0]   open_start;
        logic [POSITION_BITS-1:0]   open_length;
        t_result                    pending_tokens [$];
        int                         predicted_count;
        int                         mismatches;

        function new();
            foreach (drop_words[i]) begin
                drop_words[i] = '0;
                stop_words[i] = '0;
            end
            in_token        = 1'b0;
            position        = '0;
            open_start      = '0;
            open_length     = '0;
            predicted_count = 0;
            mismatches      = 0;
        endfunction

        function void write_class(logic [CFG_IDX_BITS-1:0] idx, logic [CLASS_WORD_BITS-1:0] data);
            if (idx < CFG_STOP_BASE) begin
                drop_words[idx[1:0]] = data;
            end else if (idx < CFG_REG_COUNT) begin
                stop_words[idx[1:0]] = data;
            end
        endfunction

        function logic [POSITION_BITS-1:0] bump(logic [POSITION_BITS-1:0] v);
            return (&v) ? v : v + 1'b1;
        endfunction

        function t_result make_token(t_kind k, logic [POSITION_BITS-1:0] s,
                                     logic [POSITION_BITS-1:0] l, logic [BYTE_BITS-1:0] d);
            t_result r;
            r.kind   = k;
            r.start  = s;
            r.length = l;
            r.delim  = d;
            r.last   = 1'b0;
            return r;
        endfunction

        // Works out the tokens that one accepted text byte releases.
        function void note_byte(logic [BYTE_BITS-1:0] c);
            t_result found [2];
            int      n;
            logic    drop_hit;
            logic    stop_hit;
            n        = 0;
            drop_hit = drop_words[c[7:6]][c[5:0]];
            stop_hit = stop_words[c[7:6]][c[5:0]];
            if (c == 8'h00) begin
                if (in_token) begin
                    found[n] = make_token(KIND_CONTENT, open_start, open_length, '0);
                    n++;
                end
                found[n] = make_token(KIND_END, position, '0, '0);
                n++;
                in_token    = 1'b0;
                position    = '0;
                open_start  = '0;
                open_length = '0;
            end else if (drop_hit || stop_hit) begin
                if (in_token) begin
                    found[n] = make_token(KIND_CONTENT, open_start, open_length, '0);
                    n++;
                    in_token = 1'b0;
                end
                // A byte flagged in both classes is dropped.
                if (!drop_hit) begin
                    found[n] = make_token(KIND_DELIM, position, POSITION_BITS'(1), c);
                    n++;
                end
                position = bump(position);
            end else begin
                if (in_token) begin
                    open_length = bump(open_length);
                end else begin
                    in_token    = 1'b1;
                    open_start  = position;
                    open_length = POSITION_BITS'(1);
                end
                position = bump(position);
            end
            for (int i = 0; i < n; i++) begin
                found[i].last = (i == n - 1);
                pending_tokens.push_back(found[i]);
                predicted_count++;
            end
        endfunction

        task report(string what);
            $display("mismatch at %0t: %s", $realtime, what);
            mismatches++;
        endtask

        task check_token(t_result got);
            t_result want;
            if (pending_tokens.size() == 0) begin
                report($sformatf("unexpected token kind %0d start %0d length %0d",
                                 got.kind, got.start, got.length));
                return;
            end
            want = pending_tokens.pop_front();
            if (got.kind !== want.kind)
                report($sformatf("kind %0d, want %0d", got.kind, want.kind));
            if (got.start !== want.start)
                report($sformatf("start %0d, want %0d", got.start, want.start));
            if (got.length !== want.length)
                report($sformatf("length %0d, want %0d", got.length, want.length));
            if (got.delim !== want.delim)
                report($sformatf("delimiter %02h, want %02h", got.delim, want.delim));
            if (got.last !== want.last)
                report($sformatf("last flag %0b, want %0b", got.last, want.last));
        endtask
    endclass

    logic                        clk          = 1'b0;
    logic                        rst_n        = 1'b0;
    logic                        in_valid     = 1'b0;
    logic                        in_stall;
    logic [BYTE_BITS-1:0]        text_byte    = '0;
    logic                        cfg_we       = 1'b0;
    logic [CFG_IDX_BITS-1:0]     cfg_index    = '0;
    logic [CLASS_WORD_BITS-1:0]  cfg_data     = '0;
    logic                        out_valid;
    logic                        out_stall    = 1'b0;
    logic [1:0]                  token_kind;
    logic [POSITION_BITS-1:0]    token_start;
    logic [POSITION_BITS-1:0]    token_length;
    logic [BYTE_BITS-1:0]        delim_byte;
    logic                        last_result;

    token_scoreboard             sb;
    logic [CLASS_WORD_BITS-1:0]  drop_cfg [CLASS_WORDS];
    logic [CLASS_WORD_BITS-1:0]  stop_cfg [CLASS_WORDS];
    int                          send_idle_pct  = 0;
    int                          recv_stall_pct = 0;
    int                          end_pct        = 6;
    int                          holdoff_left   = 0;
    int                          quiet_cycles   = 0;

    delimiter_class_tokenizer u_dut (
        .i_clk          (clk),
        .i_rst_n        (rst_n),
        .i_in_valid     (in_valid),
        .o_in_stall     (in_stall),
        .i_text_byte    (text_byte),
        .i_cfg_we       (cfg_we),
        .i_cfg_index    (cfg_index),
        .i_cfg_data     (cfg_data),
        .o_out_valid    (out_valid),
        .i_out_stall    (out_stall),
        .o_token_kind   (token_kind),
        .o_token_start  (token_start),
        .o_token_length (token_length),
        .o_delim_byte   (delim_byte),
        .o_last_result  (last_result)
    );

    always #6 clk = ~clk;

    // Receiver: checks every accepted result and stalls at random or for a
    // requested hold-off.
    initial begin
        t_result got;
        forever begin
            @(posedge clk);
            if (rst_n && out_valid && !out_stall) begin
                got.kind   = t_kind'(token_kind);
                got.start  = token_start;
                got.length = token_length;
                got.delim  = delim_byte;
                got.last   = last_result;
                sb.check_token(got);
            end
            if (holdoff_left > 0) begin
                holdoff_left--;
                out_stall <= 1'b1;
            end else begin
                out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("timeout: no request moved for %0d cycles", QUIET_LIMIT);
            $display("FAILURE");
            $finish;
        end
    end

    task send_byte(input logic [BYTE_BITS-1:0] b);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        text_byte <= b;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_byte(b);
    endtask

    // Stops the sender and lets the block empty before a register write.
    task wait_idle();
        in_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task write_classes();
        for (int i = 0; i < CLASS_WORDS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_DROP_BASE + CFG_IDX_BITS'(i);
            cfg_data  <= drop_cfg[i];
            @(posedge clk);
            sb.write_class(CFG_DROP_BASE + CFG_IDX_BITS'(i), drop_cfg[i]);
        end
        for (int i = 0; i < CLASS_WORDS; i++) begin
            cfg_we    <= 1'b1;
            cfg_index <= CFG_STOP_BASE + CFG_IDX_BITS'(i);
            cfg_data  <= stop_cfg[i];
            @(posedge clk);
            sb.write_class(CFG_STOP_BASE + CFG_IDX_BITS'(i), stop_cfg[i]);
        end
        // A write past the last register must leave the classes alone.
        cfg_index <= CFG_IDX_BITS'($urandom_range(CFG_REG_COUNT, {CFG_IDX_BITS{1'b1}}));
        cfg_data  <= {$urandom, $urandom};
        @(posedge clk);
        sb.write_class(cfg_index, cfg_data);
        cfg_we <= 1'b0;
    endtask

    function automatic void add_char(input bit to_drop, input logic [7:0] c);
        if (to_drop) drop_cfg[c[7:6]][c[5:0]] = 1'b1;
        else stop_cfg[c[7:6]][c[5:0]] = 1'b1;
    endfunction

    function automatic logic [CLASS_WORD_BITS-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task set_class_style(input int style);
        foreach (drop_cfg[i]) begin
            drop_cfg[i] = '0;
            stop_cfg[i] = '0;
        end
        end_pct = 6;
        case (style)
            0: begin
                // Whitespace is dropped, punctuation splits; space is in both.
                add_char(1'b1, 8'h20); add_char(1'b1, 8'h09); add_char(1'b1, 8'h0A);
                add_char(1'b1, 8'h0D); add_char(1'b1, 8'hFF); add_char(1'b1, 8'h00);
                add_char(1'b0, 8'h2C); add_char(1'b0, 8'h3B); add_char(1'b0, 8'h28);
                add_char(1'b0, 8'h29); add_char(1'b0, 8'h80); add_char(1'b0, 8'h01);
                add_char(1'b0, 8'h20); add_char(1'b0, 8'h00);
            end
            2: begin
                foreach (drop_cfg[i]) drop_cfg[i] = '1;
                end_pct = 20;
            end
            3: begin
                foreach (stop_cfg[i]) stop_cfg[i] = '1;
            end
            5: begin
                foreach (drop_cfg[i]) begin
                    drop_cfg[i] = rand_word() & rand_word() & rand_word();
                    stop_cfg[i] = rand_word() & rand_word() & rand_word();
                end
            end
            6: begin
                foreach (drop_cfg[i]) begin
                    drop_cfg[i] = '1;
                    stop_cfg[i] = '1;
                end
                end_pct = 20;
            end
            1, 7: begin
                foreach (drop_cfg[i]) begin
                    drop_cfg[i] = rand_word();
                    stop_cfg[i] = rand_word();
                end
            end
            default: ;
        endcase
    endtask

    function automatic logic [7:0] class_member(input bit from_drop);
        logic [7:0] c;
        repeat (16) begin
            c = 8'($urandom_range(1, 255));
            if (from_drop ? drop_cfg[c[7:6]][c[5:0]] : stop_cfg[c[7:6]][c[5:0]])
                return c;
        end
        return 8'($urandom_range(1, 255));
    endfunction

    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < end_pct) return 8'h00;
        if (r < end_pct + 20) return class_member(1'b1);
        if (r < end_pct + 35) return class_member(1'b0);
        return 8'($urandom_range(1, 255));
    endfunction

    task run_random_text(input int n_items);
        int sent;
        sent = 0;
        while (sent < n_items) begin
            send_byte(pick_text_byte());
            sent++;
        end
    endtask

    initial begin
        sb = new();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // With all classes clear every nonzero byte is content.
        foreach (PLAIN_TEXT[i]) send_byte(PLAIN_TEXT[i]);

        wait_idle();
        set_class_style(0);
        write_classes();
        foreach (CLASS_TEXT[i]) send_byte(CLASS_TEXT[i]);

        for (int p = 0; p < 8; p++) begin
            wait_idle();
            set_class_style(p);
            write_classes();
            case (p % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
                default: begin send_idle_pct = 32; recv_stall_pct = 32; end
            endcase
            // The receiver holds off while requests keep coming, so the
            // result queue fills and the input stalls.
            if (p == 0) holdoff_left = HOLDOFF_CYCLES;
            run_random_text(125);
        end

        in_valid <= 1'b0;
        while (sb.pending_tokens.size() != 0) @(posedge clk);
        repeat (END_CYCLES) @(posedge clk);
        if (sb.mismatches == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule
